// ===== rtl/core/vlpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlpd_pkg
// Types and constants shared by the length-prefix deframer modules.
// ----------------------------------------------------------------------------
package vlpd_pkg;

  localparam logic [1:0] PhPrefix  = 2'd0;
  localparam logic [1:0] PhPayload = 2'd1;
  localparam logic [1:0] PhDiscard = 2'd2;

  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatMalformed = 2'd1,
    StatTruncated = 2'd2,
    StatDiscard   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] length_accum;
    logic [2:0]  prefix_cnt;
    logic [31:0] remaining;
    logic [7:0]  field_cnt;
  } state_t;

  typedef struct packed {
    logic        field_start;
    logic [31:0] field_length;
    logic        payload_valid;
    logic [7:0]  data_out;
    logic        field_end;
    logic [7:0]  field_index;
    status_e     status;
    logic        value_done;
  } result_t;

endpackage

// ===== rtl/core/vlpd_pipe_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlpd_pipe_reg
// One-entry pipeline register with valid/ready flow control.
// ----------------------------------------------------------------------------
module vlpd_pipe_reg #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ===== rtl/core/vlpd_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlpd_step
// Per-byte decode: next deframer state and the result for one byte.
// ----------------------------------------------------------------------------
module vlpd_step #(
  parameter int unsigned MaxFields = 256
) (
  input  vlpd_pkg::state_t  state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              value_last_i,
  output vlpd_pkg::state_t  state_d_o,
  output vlpd_pkg::result_t result_o
);

  localparam logic [7:0] FieldCap = (MaxFields - 1 > 255) ? 8'd255 : 8'(MaxFields - 1);

  logic [31:0] accum;
  logic [31:0] rem_dec;
  logic [7:0]  cnt_next;
  vlpd_pkg::state_t  st;
  vlpd_pkg::result_t res;

  assign cnt_next = (state_i.field_cnt < FieldCap) ? state_i.field_cnt + 8'd1
                                                   : state_i.field_cnt;
  assign rem_dec  = (state_i.remaining != 32'd0) ? state_i.remaining - 32'd1 : 32'd0;

  always_comb begin
    case (state_i.prefix_cnt)
      3'd0:    accum = state_i.length_accum | {25'd0, data_byte_i[6:0]};
      3'd1:    accum = state_i.length_accum | {18'd0, data_byte_i[6:0], 7'd0};
      3'd2:    accum = state_i.length_accum | {11'd0, data_byte_i[6:0], 14'd0};
      3'd3:    accum = state_i.length_accum | {4'd0, data_byte_i[6:0], 21'd0};
      default: accum = state_i.length_accum | {data_byte_i[3:0], 28'd0};
    endcase
  end

  always_comb begin
    st  = state_i;
    res = '0;
    res.field_index = state_i.field_cnt;
    res.value_done  = value_last_i;
    res.status      = vlpd_pkg::StatOk;
    unique case (state_i.phase)
      vlpd_pkg::PhPrefix: begin
        st.length_accum = accum;
        if (data_byte_i[7]) begin
          if (state_i.prefix_cnt >= 3'd4) begin
            res.status = vlpd_pkg::StatMalformed;
            st.phase   = vlpd_pkg::PhDiscard;
          end else begin
            st.prefix_cnt = state_i.prefix_cnt + 3'd1;
            if (value_last_i) begin
              res.status = vlpd_pkg::StatTruncated;
            end
          end
        end else begin
          res.field_start  = 1'b1;
          res.field_length = accum;
          if (accum == 32'd0) begin
            res.field_end   = 1'b1;
            st.field_cnt    = cnt_next;
            st.length_accum = '0;
            st.prefix_cnt   = '0;
            st.remaining    = '0;
            st.phase        = vlpd_pkg::PhPrefix;
          end else begin
            st.remaining  = accum;
            st.prefix_cnt = '0;
            st.phase      = vlpd_pkg::PhPayload;
            if (value_last_i) begin
              res.status = vlpd_pkg::StatTruncated;
            end
          end
        end
      end
      vlpd_pkg::PhPayload: begin
        res.payload_valid = 1'b1;
        res.data_out      = data_byte_i;
        res.field_length  = state_i.length_accum;
        st.remaining      = rem_dec;
        if (rem_dec == 32'd0) begin
          res.field_end   = 1'b1;
          st.field_cnt    = cnt_next;
          st.length_accum = '0;
          st.prefix_cnt   = '0;
          st.phase        = vlpd_pkg::PhPrefix;
        end else if (value_last_i) begin
          res.status = vlpd_pkg::StatTruncated;
        end
      end
      default: begin
        res.status = vlpd_pkg::StatDiscard;
      end
    endcase
    if (value_last_i) begin
      st = '0;
    end
  end

  assign state_d_o = st;
  assign result_o  = res;

endmodule

// ===== rtl/core/varint_length_prefix_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_length_prefix_deframer
// Splits a byte stream into varint32 length-prefixed fields and reports
// field starts, lengths, payload bytes, field ends and errors.
// ----------------------------------------------------------------------------
// Channel  Dir  Transaction      tdata                         tlast
// s_axis   in   one input byte   data_byte                     value_last
// m_axis   out  one result       field_start..status (packed)  value_done
//
// One result per byte; a byte passes the input register and is then decoded
// into the result register, and one byte is taken every cycle while the
// output is drained.
// Reset clears the decode state and both stage valids.
// A stall on m_axis holds the result register; the input register then
// fills and s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module varint_length_prefix_deframer #(
  parameter int unsigned MaxFields = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] field_start, [32:1] field_length, [33] payload_valid,
  // [41:34] data_out, [42] field_end, [50:43] field_index,
  // [52:51] status, [55:53] zero
  output logic [55:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic              in_valid;
  logic              out_ready;
  logic [8:0]        in_data;
  logic              advance;
  vlpd_pkg::state_t  state_q;
  vlpd_pkg::state_t  state_d;
  vlpd_pkg::result_t res;
  logic [56:0]       out_word;
  logic [56:0]       out_q;

  vlpd_pipe_reg #(
    .Width (9)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  ({s_axis_tlast_i, s_axis_tdata_i}),
    .valid_o (in_valid),
    .ready_i (out_ready),
    .data_o  (in_data)
  );

  vlpd_step #(
    .MaxFields (MaxFields)
  ) u_step (
    .state_i      (state_q),
    .data_byte_i  (in_data[7:0]),
    .value_last_i (in_data[8]),
    .state_d_o    (state_d),
    .result_o     (res)
  );

  assign advance = in_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_word = {res.value_done, 3'd0, res.status, res.field_index, res.field_end,
                     res.data_out, res.payload_valid, res.field_length, res.field_start};

  vlpd_pipe_reg #(
    .Width (57)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (out_ready),
    .data_i  (out_word),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_q)
  );

  assign m_axis_tdata_o = out_q[55:0];
  assign m_axis_tlast_o = out_q[56];

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_data[8] |=> state_q.phase == vlpd_pkg::PhPrefix
                              && state_q.field_cnt == 8'd0
                              && state_q.length_accum == 32'd0)
    else $error("state not cleared after value end");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == vlpd_pkg::PhPayload |-> state_q.remaining != 32'd0)
    else $error("payload phase with nothing remaining");

  a_zero_len_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] && m_axis_tdata_o[32:1] == 32'd0
    |-> m_axis_tdata_o[42])
    else $error("empty field without field end");

  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[33]
    |-> !m_axis_tdata_o[0] && m_axis_tdata_o[52:51] != vlpd_pkg::StatMalformed
        && m_axis_tdata_o[52:51] != vlpd_pkg::StatDiscard)
    else $error("payload byte with bad flags");

endmodule

// ===== tb/sv/vlpd_deframe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlpd_deframe_checker
// Watches both stream channels of the length-prefix deframer. It decodes
// every accepted input byte with its own copy of the deframer state, queues
// the expected result, and compares each output transaction field by field
// against the oldest queued result.
// ----------------------------------------------------------------------------
module vlpd_deframe_checker #(
  parameter int unsigned MaxFields = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  output int          err_cnt_o,
  output int          pending_o
);

  localparam int unsigned FieldCap = (MaxFields - 1 > 255) ? 255 : MaxFields - 1;

  logic [1:0]  phase_q;
  logic [31:0] length_q;
  logic [2:0]  prefix_cnt_q;
  logic [31:0] remaining_q;
  logic [7:0]  field_cnt_q;

  vlpd_pkg::result_t pending_results_q[$];

  function automatic void clear_state();
    phase_q      = vlpd_pkg::PhPrefix;
    length_q     = '0;
    prefix_cnt_q = '0;
    remaining_q  = '0;
    field_cnt_q  = '0;
  endfunction

  function automatic void close_field();
    if (field_cnt_q < FieldCap) field_cnt_q = field_cnt_q + 8'd1;
    length_q     = '0;
    prefix_cnt_q = '0;
    remaining_q  = '0;
    phase_q      = vlpd_pkg::PhPrefix;
  endfunction

  function automatic vlpd_pkg::result_t decode_byte(input logic [7:0] b, input logic last);
    vlpd_pkg::result_t r;
    logic [2:0]        n;
    r             = '0;
    r.status      = vlpd_pkg::StatOk;
    r.field_index = field_cnt_q;
    r.value_done  = last;
    n             = prefix_cnt_q;
    case (phase_q)
      vlpd_pkg::PhPrefix: begin
        if (n < 3'd4) length_q = length_q | (32'(b[6:0]) << (7 * n));
        else length_q = length_q | {b[3:0], 28'd0};
        if (b[7]) begin
          if (n >= 3'd4) begin
            r.status = vlpd_pkg::StatMalformed;
            phase_q  = vlpd_pkg::PhDiscard;
          end else begin
            prefix_cnt_q = n + 3'd1;
            if (last) r.status = vlpd_pkg::StatTruncated;
          end
        end else begin
          r.field_start  = 1'b1;
          r.field_length = length_q;
          if (length_q == '0) begin
            r.field_end = 1'b1;
            close_field();
          end else begin
            remaining_q  = length_q;
            prefix_cnt_q = '0;
            phase_q      = vlpd_pkg::PhPayload;
            if (last) r.status = vlpd_pkg::StatTruncated;
          end
        end
      end
      vlpd_pkg::PhPayload: begin
        r.payload_valid = 1'b1;
        r.data_out      = b;
        r.field_length  = length_q;
        if (remaining_q != '0) remaining_q = remaining_q - 32'd1;
        if (remaining_q == '0) begin
          r.field_end = 1'b1;
          close_field();
        end else if (last) begin
          r.status = vlpd_pkg::StatTruncated;
        end
      end
      default: begin
        r.status = vlpd_pkg::StatDiscard;
      end
    endcase
    if (last) clear_state();
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt_o++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    vlpd_pkg::result_t exp_r;
    vlpd_pkg::result_t act_r;
    if (!rst_ni) begin
      clear_state();
      pending_results_q.delete();
      pending_o = 0;
    end else begin
      // outputs first: a byte accepted at this edge cannot show up yet
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        act_r.field_start   = m_axis_tdata_i[0];
        act_r.field_length  = m_axis_tdata_i[32:1];
        act_r.payload_valid = m_axis_tdata_i[33];
        act_r.data_out      = m_axis_tdata_i[41:34];
        act_r.field_end     = m_axis_tdata_i[42];
        act_r.field_index   = m_axis_tdata_i[50:43];
        act_r.status        = vlpd_pkg::status_e'(m_axis_tdata_i[52:51]);
        act_r.value_done    = m_axis_tlast_i;
        if (pending_results_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: unexpected result: expected none, actual 0x%0h",
                   $time, m_axis_tdata_i);
        end else begin
          exp_r = pending_results_q.pop_front();
          cmp_field("field_start", exp_r.field_start, act_r.field_start);
          cmp_field("field_length", exp_r.field_length, act_r.field_length);
          cmp_field("payload_valid", exp_r.payload_valid, act_r.payload_valid);
          cmp_field("data_out", exp_r.data_out, act_r.data_out);
          cmp_field("field_end", exp_r.field_end, act_r.field_end);
          cmp_field("field_index", exp_r.field_index, act_r.field_index);
          cmp_field("status", exp_r.status, act_r.status);
          cmp_field("value_done", exp_r.value_done, act_r.value_done);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pending_results_q.push_back(decode_byte(s_axis_tdata_i, s_axis_tlast_i));
      end
      pending_o = pending_results_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_varint_length_prefix_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_varint_length_prefix_deframer
// Drives encoded values into the deframer: a few directed values for the
// prefix extremes, zero-length fields, malformed and truncated values, one
// that saturates the field number, then random values (mostly well-formed,
// some broken or noise). Both sides idle at random; the output is held off
// once for a long stretch and the input pauses once until drained.
// ----------------------------------------------------------------------------
module tb_varint_length_prefix_deframer;

  localparam int unsigned MaxFields  = 256;
  localparam int          RandBytes  = 750;
  localparam int          CycleLimit = 100000;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;

  int          err_cnt;
  int          pending;
  int          cycles   = 0;
  bit          tx_idle  = 1'b1;
  bit          rx_idle  = 1'b1;
  bit          hold_req = 1'b0;
  logic [7:0]  val_q[$];

  always #5 clk_i = ~clk_i;

  varint_length_prefix_deframer #(
    .MaxFields(MaxFields)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  vlpd_deframe_checker #(
    .MaxFields(MaxFields)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tlast_i (m_tlast),
    .err_cnt_o      (err_cnt),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one transaction; tvalid stays high when the next byte follows at once
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic send_value();
    int n;
    n = val_q.size();
    for (int i = 0; i < n; i++) send_byte(val_q[i], i == n - 1);
    val_q.delete();
  endtask

  task automatic push_length(input int unsigned len, input int unsigned pad);
    int unsigned v;
    int unsigned p;
    logic [7:0]  grp[$];
    v = len;
    p = pad;
    do begin
      grp.push_back({1'b0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
    // redundant continuation groups, still within five bytes
    while (p > 0 && grp.size() < 5) begin
      grp[grp.size() - 1][7] = 1'b1;
      grp.push_back(8'h00);
      p--;
    end
    foreach (grp[i]) val_q.push_back(grp[i]);
  endtask

  task automatic push_payload(input int unsigned n);
    repeat (n) val_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_fields(input int nf);
    int unsigned len;
    repeat (nf) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 150) : $urandom_range(0, 6);
      push_length(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      push_payload(len);
    end
  endtask

  task automatic build_random_value();
    int k;
    int cut;
    k = $urandom_range(0, 9);
    if (k <= 5) begin
      build_fields($urandom_range(1, 4));
    end else if (k == 6) begin
      build_fields($urandom_range(1, 3));
      cut = $urandom_range(1, val_q.size());
      while (val_q.size() > cut) void'(val_q.pop_back());
    end else if (k == 7) begin
      build_fields($urandom_range(0, 2));
      repeat (5) val_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
      push_payload($urandom_range(0, 3));
    end else if (k == 8) begin
      push_payload($urandom_range(1, 8));
    end else begin
      repeat (4) val_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
      val_q.push_back(8'($urandom_range(0, 127)));
      push_payload($urandom_range(0, 4));
    end
  endtask

  initial begin : rx_proc
    int gap;
    int n;
    n = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      if (n % 25 == 0) rx_idle = ($urandom_range(0, 2) != 0);
      gap = rx_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      n++;
    end
  end

  initial begin : stim_proc
    int sent;
    int nval;
    sent = 0;
    nval = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-length field alone
    val_q.push_back(8'h00);
    send_value();
    // two-byte payload
    val_q = '{8'h02, 8'hAA, 8'h55};
    send_value();
    // largest length, truncated right at the prefix
    val_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F};
    send_value();
    // fifth byte high bits dropped: length zero, then one more field
    val_q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h70, 8'h01, 8'hFF};
    send_value();
    // continuation on fifth byte, rest discarded
    val_q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h12, 8'h34};
    send_value();
    // value ends inside a prefix
    val_q.push_back(8'h85);
    send_value();
    // value ends inside a payload
    val_q = '{8'h03, 8'h11};
    send_value();

    // field number saturation
    tx_idle = 1'b0;
    repeat (300) begin
      if ($urandom_range(0, 1) != 0) begin
        val_q.push_back(8'h00);
      end else begin
        val_q.push_back(8'h01);
        push_payload(1);
      end
    end
    sent += val_q.size();
    send_value();

    while (sent < RandBytes) begin
      nval++;
      tx_idle = ($urandom_range(0, 3) != 0);
      if (nval == 20) begin
        hold_req = 1'b1;
        tx_idle  = 1'b0;
      end
      if (nval == 40) begin
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(posedge clk_i);
      end
      build_random_value();
      sent += val_q.size();
      send_value();
    end
    s_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/vlpd_pkg.sv
rtl/core/vlpd_pipe_reg.sv
rtl/core/vlpd_step.sv
rtl/core/varint_length_prefix_deframer.sv
tb/sv/vlpd_deframe_checker.sv
tb/sv/tb_varint_length_prefix_deframer.sv
